/* rtl/srle_pkg.sv */
`default_nettype none

package srle_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int CFG_BITS        = 24;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_IDX_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_blob;
  } srle_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] repeat_res;
    logic       last_of_blob;
  } srle_out_t;

  // classified beat as held in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_blob;
    logic       lit_header;
    logic [7:0] lit_count;
    logic [6:0] run_len;
  } srle_item_t;

endpackage

`default_nettype wire

/* rtl/signed_rle_byte_decoder_top.sv */
// signed run-length byte decoder
// in_*: one compressed byte per beat, start_of_blob marks a header that restarts decoding
// out_*: one decoded result per beat (value, repeat count 1..127, last of blob)
// cfg_*: writes the output length; cfg_ready is always high, write only while idle
// a beat is taken when valid is high and stall is low
// a two-entry queue sits between the input classifier and the decode engine
// a result-producing byte passes through the queue and then the output register to out_valid
// one byte per cycle while out_stall is low, limited by the single decode state update per beat
// header bytes, zero-length runs and bytes once the output length is reached give no result
// the output register keeps its beat stable while out_stall is high; the queue
// then fills and in_stall rises once both entries are held
// reset (synchronous, rst_n low) empties the queue, drops any held result,
// clears the output length and returns the decoder to expecting a header
`default_nettype none

module signed_rle_byte_decoder_top #(
  parameter int LENGTH_BITS = srle_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire srle_pkg::srle_in_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output srle_pkg::srle_out_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [srle_pkg::CFG_BITS-1:0] cfg_data
);
  import srle_pkg::*;

  logic       q_valid;
  logic       q_pop;
  srle_item_t q_item;

  assign cfg_ready = 1'b1;

  srle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  srle_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/srle_front.sv */
`default_nettype none

module srle_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srle_pkg::srle_in_t  in_data,
  output logic                     q_valid,
  input  wire logic                q_pop,
  output srle_pkg::srle_item_t     q_item
);
  import srle_pkg::*;

  srle_item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_IDX_BITS-1:0]   wr_ptr_r;
  logic [QUEUE_IDX_BITS-1:0]   wr_ptr_nxt;
  logic [QUEUE_IDX_BITS-1:0]   rd_ptr_r;
  logic [QUEUE_IDX_BITS-1:0]   rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0]   cnt_r;
  logic [QUEUE_CNT_BITS-1:0]   cnt_nxt;
  srle_item_t                  item;
  logic                        push;
  logic                        pop;

  // header interpretation: negative means literal count, -128 gives 128
  always_comb begin
    item.data_byte     = in_data.data_byte;
    item.start_of_blob = in_data.start_of_blob;
    item.lit_header    = in_data.data_byte[7];
    item.lit_count     = 8'd0 - in_data.data_byte;
    item.run_len       = in_data.data_byte[6:0];
  end

  assign in_stall = (cnt_r == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/srle_back.sv */
`default_nettype none

module srle_back #(
  parameter int LENGTH_BITS = srle_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire srle_pkg::srle_item_t         q_item,
  input  wire logic                         cfg_valid,
  input  wire logic [srle_pkg::CFG_BITS-1:0] cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output srle_pkg::srle_out_t               out_data
);
  import srle_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_RUNVAL  = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  logic [LENGTH_BITS-1:0]          len_r;
  logic [LENGTH_BITS+CFG_BITS-1:0] cfg_wide;
  logic [1:0]                      phase_r;
  logic [1:0]                      phase_nxt;
  logic [7:0]                      lit_r;
  logic [7:0]                      lit_nxt;
  logic [6:0]                      run_r;
  logic [6:0]                      run_nxt;
  logic [LENGTH_BITS-1:0]          wr_r;
  logic [LENGTH_BITS-1:0]          wr_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  srle_out_t                       out_data_r;

  logic [1:0]                      ph;
  logic [7:0]                      lit;
  logic [6:0]                      run;
  logic [LENGTH_BITS-1:0]          wr;
  logic [LENGTH_BITS-1:0]          room;
  logic [LENGTH_BITS-1:0]          run_ext;
  logic [LENGTH_BITS-1:0]          step;
  logic                            res_valid;
  srle_out_t                       res;

  assign cfg_wide  = {{LENGTH_BITS{1'b0}}, cfg_data};
  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ph  = q_item.start_of_blob ? PH_HEADER : phase_r;
    lit = q_item.start_of_blob ? 8'd0 : lit_r;
    run = q_item.start_of_blob ? 7'd0 : run_r;
    wr  = q_item.start_of_blob ? '0 : wr_r;

    room    = len_r - wr;
    run_ext = {{(LENGTH_BITS-7){1'b0}}, run};
    step    = (run_ext < room) ? run_ext : room;

    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    run_nxt   = run_r;
    wr_nxt    = wr_r;
    res_valid = 1'b0;
    res.value        = q_item.data_byte;
    res.repeat_res   = 8'd1;
    res.last_of_blob = 1'b0;

    if (q_pop) begin
      phase_nxt = ph;
      lit_nxt   = lit;
      run_nxt   = run;
      wr_nxt    = wr;
      if (ph == PH_DONE) begin
        phase_nxt = PH_DONE;
      end else if (wr >= len_r) begin
        phase_nxt = PH_DONE;
      end else begin
        unique case (ph)
          PH_HEADER: begin
            if (q_item.lit_header) begin
              lit_nxt   = q_item.lit_count;
              phase_nxt = PH_LITERAL;
            end else begin
              run_nxt   = q_item.run_len;
              phase_nxt = PH_RUNVAL;
            end
          end
          PH_LITERAL: begin
            res_valid        = 1'b1;
            res.last_of_blob = (room == LENGTH_BITS'(1));
            wr_nxt           = wr + 1'b1;
            lit_nxt          = lit - 8'd1;
            if (res.last_of_blob) begin
              phase_nxt = PH_DONE;
            end else if (lit == 8'd1) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_RUNVAL: begin
            if (run == 7'd0) begin
              phase_nxt = PH_HEADER;
            end else begin
              res_valid        = 1'b1;
              res.repeat_res   = step[7:0];
              res.last_of_blob = (step == room);
              wr_nxt           = wr + step;
              run_nxt          = 7'd0;
              phase_nxt        = res.last_of_blob ? PH_DONE : PH_HEADER;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end

    if (q_pop && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      lit_r       <= '0;
      run_r       <= '0;
      wr_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      lit_r       <= lit_nxt;
      run_r       <= run_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        len_r <= cfg_wide[LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_signed_rle_byte_decoder_top.sv */
`timescale 1ns / 1ps

module tb_signed_rle_byte_decoder_top;
  import srle_pkg::*;

  localparam int LEN_BITS     = LENGTH_BITS_DEF;
  localparam int TARGET_BYTES = 1350;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED   = 22;

  typedef enum logic [1:0] {
    WANT_HEADER,
    IN_LITERALS,
    WANT_RUN_VALUE,
    BLOB_FULL
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sob;
    logic       typed;
    logic       has_result;
    srle_out_t  res;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  srle_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  srle_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // decoder state as predicted
  dec_phase_e          dec_phase = WANT_HEADER;
  logic [7:0]          lits_left = '0;
  logic [6:0]          run_len   = '0;
  logic [LEN_BITS-1:0] written   = '0;
  logic [LEN_BITS-1:0] out_len   = '0;

  srle_out_t pending_results[$];
  srle_out_t want_res;
  int        errors        = 0;
  int        cycles        = 0;
  int        decoded_bytes = 0;
  int        sent_bytes    = 0;
  int        phase_bytes   = 0;
  int        stall_hold    = 0;
  int        stall_pick;
  bit        gaps_on       = 1'b1;
  bit        stalls_on     = 1'b1;

  dir_row_t dir_rows [N_DIRECTED];

  signed_rle_byte_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // returns 1 when the byte yields a result; acted is 0 for an ignored byte
  function automatic bit decode_byte(input srle_in_t beat, output srle_out_t res,
                                     output bit acted);
    logic [LEN_BITS-1:0] room;
    logic [LEN_BITS-1:0] span;
    bit                  last;
    res   = '0;
    acted = 1'b0;
    if (beat.start_of_blob) begin
      dec_phase = WANT_HEADER;
      lits_left = '0;
      run_len   = '0;
      written   = '0;
    end
    if (dec_phase == BLOB_FULL) return 1'b0;
    if (written >= out_len) begin
      dec_phase = BLOB_FULL;
      return 1'b0;
    end
    acted = 1'b1;
    room  = out_len - written;
    case (dec_phase)
      WANT_HEADER: begin
        if (beat.data_byte[7]) begin
          // negation of 0x80 wraps to 128 literals
          lits_left = 8'd0 - beat.data_byte;
          dec_phase = IN_LITERALS;
        end else begin
          run_len   = beat.data_byte[6:0];
          dec_phase = WANT_RUN_VALUE;
        end
        return 1'b0;
      end
      IN_LITERALS: begin
        last      = (room == LEN_BITS'(1));
        written   = written + LEN_BITS'(1);
        lits_left = lits_left - 8'd1;
        if (last) begin
          dec_phase = BLOB_FULL;
        end else if (lits_left == 8'd0) begin
          dec_phase = WANT_HEADER;
        end
        res = '{value: beat.data_byte, repeat_res: 8'd1, last_of_blob: last};
        return 1'b1;
      end
      default: begin
        if (run_len == 7'd0) begin
          dec_phase = WANT_HEADER;
          return 1'b0;
        end
        span      = (LEN_BITS'(run_len) < room) ? LEN_BITS'(run_len) : room;
        last      = (span == room);
        written   = written + span;
        run_len   = '0;
        dec_phase = last ? BLOB_FULL : WANT_HEADER;
        res = '{value: beat.data_byte, repeat_res: span[7:0], last_of_blob: last};
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_BITS'($urandom_range(1, 64));
    if (r < 85) return CFG_BITS'($urandom_range(65, 2000));
    return CFG_BITS'($urandom);
  endfunction

  // typed rows carry their own expectation, the rest use the predictor
  task automatic send_byte(input logic [7:0] data, input bit sob, input bit typed,
                           input bit t_has, input srle_out_t t_res);
    int        gap;
    srle_in_t  beat;
    srle_out_t res;
    bit        has;
    bit        acted;
    gap  = pick_gap();
    beat = '{data_byte: data, start_of_blob: sob};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_byte(beat, res, acted);
    if (typed) begin
      has = t_has;
      res = t_res;
    end
    if (has) pending_results.push_back(res);
    if (acted) decoded_bytes++;
    sent_bytes++;
    phase_bytes++;
  endtask

  task automatic send_plain(input logic [7:0] data, input bit sob);
    send_byte(data, sob, 1'b0, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_BITS-1:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    out_len = LEN_BITS'(len);
  endtask

  // header plus content, now and then a broken or stray beat
  task automatic random_blob();
    int groups;
    int g;
    int k;
    int n;
    int pick;
    bit sob;
    groups = $urandom_range(1, 8);
    sob    = 1'b1;
    for (g = 0; g < groups; g++) begin
      pick = $urandom_range(0, 99);
      if (g > 0 && pick < 8) begin
        send_plain(8'($urandom), ($urandom_range(0, 7) == 0));
      end else if (pick < 54) begin
        k = $urandom_range(0, 99);
        if (k < 80) begin
          n = $urandom_range(1, 8);
        end else if (k < 95) begin
          n = $urandom_range(9, 127);
        end else begin
          n = 128;
        end
        send_plain(8'd0 - 8'(n), sob);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 99) < 2) break;
          send_plain(8'($urandom), 1'b0);
        end
      end else begin
        k = $urandom_range(0, 9);
        n = (k == 0) ? 0 : (k == 1) ? 127 : $urandom_range(1, 126);
        send_plain(8'(n), sob);
        send_plain(8'($urandom), 1'b0);
      end
      sob = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (!stalls_on) begin
      out_stall  <= 1'b0;
      stall_hold = $urandom_range(5, 40);
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 3);
      end else if (stall_pick < 92) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(5, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (errors < 50) begin
          $display("%0t: unexpected beat, got value %h repeat %0d last %0b", $time,
                   out_data.value, out_data.repeat_res, out_data.last_of_blob);
        end
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        if (want_res.value !== out_data.value ||
            want_res.repeat_res !== out_data.repeat_res ||
            want_res.last_of_blob !== out_data.last_of_blob) begin
          if (errors < 50) begin
            $display("%0t: expected value %h repeat %0d last %0b, got value %h repeat %0d last %0b",
                     $time, want_res.value, want_res.repeat_res, want_res.last_of_blob,
                     out_data.value, out_data.repeat_res, out_data.last_of_blob);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** signed_rle_byte_decoder_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int                  i;
    int                  phase_no;
    int                  target;
    int                  cap;
    logic [CFG_BITS-1:0] len;
    // output length 8 for the whole table
    dir_rows = '{
      '{8'h02, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},  // header before any blob start
      '{8'h55, 1'b0, 1'b1, 1'b1, '{8'h55, 8'd2, 1'b0}},
      '{8'h80, 1'b1, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},  // 128 literals
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 8'd1, 1'b0}},
      '{8'hff, 1'b0, 1'b1, 1'b1, '{8'hff, 8'd1, 1'b0}},
      '{8'h00, 1'b1, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},  // zero run
      '{8'haa, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h7f, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h01, 1'b0, 1'b1, 1'b1, '{8'h01, 8'd8, 1'b1}},  // run clipped to the buffer
      '{8'h33, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},  // buffer full, ignored
      '{8'h03, 1'b1, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h5a, 1'b0, 1'b1, 1'b1, '{8'h5a, 8'd3, 1'b0}},
      '{8'hfe, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h11, 1'b0, 1'b1, 1'b1, '{8'h11, 8'd1, 1'b0}},
      '{8'h22, 1'b0, 1'b1, 1'b1, '{8'h22, 8'd1, 1'b0}},
      '{8'h81, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'hc3, 1'b0, 1'b0, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h3c, 1'b0, 1'b0, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h96, 1'b0, 1'b1, 1'b1, '{8'h96, 8'd1, 1'b1}},  // literals stop at the end
      '{8'h69, 1'b0, 1'b1, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'h04, 1'b1, 1'b0, 1'b0, '{8'h00, 8'd0, 1'b0}},
      '{8'he7, 1'b0, 1'b0, 1'b0, '{8'h00, 8'd0, 1'b0}}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_length(CFG_BITS'(8));
    for (i = 0; i < N_DIRECTED; i++) begin
      send_byte(dir_rows[i].data_byte, dir_rows[i].sob, dir_rows[i].typed,
                dir_rows[i].has_result, dir_rows[i].res);
    end

    phase_no = 0;
    while (sent_bytes < TARGET_BYTES && phase_no < 60) begin
      case (phase_no)
        0: begin
          len = '0;
        end
        1: begin
          len = '1;
        end
        2: begin
          len = CFG_BITS'(1);
        end
        default: begin
          len = pick_length();
        end
      endcase
      write_length(len);
      gaps_on   = (phase_no % 5) != 3;
      stalls_on <= (phase_no % 7) != 4;
      phase_bytes = 0;
      // carry on from the previous blob without a restart
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 6)) send_plain(8'($urandom), 1'b0);
      end
      target = decoded_bytes + 120;
      cap    = (len == '0) ? 20 : 500;
      while (decoded_bytes < target && phase_bytes < cap && sent_bytes < TARGET_BYTES) begin
        random_blob();
      end
      phase_no++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("** signed_rle_byte_decoder_top: PASSED **");
    end else begin
      $display("** signed_rle_byte_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
